[sv/multi_level_priority_queue_top_defines.svh]
// Assertion macros for the multi-level priority queue.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MULTI_LEVEL_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MLPQ_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mlpq assertion failed");
`define MLPQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("mlpq assertion failed");
`else
`define MLPQ_ASSERT(lbl, clk, rstn, prop)
`define MLPQ_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[sv/mlpq_pkg.sv]
// Shared types and codes for the multi-level priority queue.
// No dependencies.
package mlpq_pkg;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic               op;
        logic signed [31:0] item_value;
        logic        [2:0]  level;
    } t_in_item;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_value;
        logic        [2:0]  out_level;
    } t_out_item;

    typedef struct packed {
        logic load_item;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

[sv/mlpq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mlpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 40
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/mlpq_ctrl.sv]
// Controller of the multi-level priority queue: sequences accept, execute, deliver.
// Depends on mlpq_pkg and the assertion macro header.
`include "multi_level_priority_queue_top_defines.svh"

module mlpq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mlpq_pkg::t_cmd o_cmd
);
    import mlpq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    t_cmd   cmd;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        cmd.load_item = (r_state == S_IDLE) && i_in_valid;
        cmd.exec      = (r_state == S_EXEC);
        cmd.load_out  = (r_state == S_DONE) && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `MLPQ_ASSERT(a_accept_exec, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
    `MLPQ_ASSERT(a_exec_done, i_clk, i_rst_n, (r_state == S_EXEC) |=> (r_state == S_DONE))
    `MLPQ_ASSERT(a_load_valid, i_clk, i_rst_n, cmd.load_out |=> r_out_valid)
    `MLPQ_ASSERT(a_cmd_excl, i_clk, i_rst_n, $onehot0({cmd.load_item, cmd.exec, cmd.load_out}))
    `MLPQ_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE) && !r_out_valid)

endmodule

[sv/mlpq_dp.sv]
// Datapath of the multi-level priority queue: level pointers, counts, slot RAM,
// priority encoder and result register. Depends on mlpq_pkg and mlpq_ram.
module mlpq_dp #(
    parameter int LEVELS          = 8,
    parameter int SLOTS_PER_LEVEL = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mlpq_pkg::t_cmd      i_cmd,
    input  mlpq_pkg::t_in_item  i_in_data,
    output mlpq_pkg::t_out_item o_out_data
);
    import mlpq_pkg::*;

    localparam int DEPTH = LEVELS * SLOTS_PER_LEVEL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int HW    = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
    localparam int OW    = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int SW    = ((HW > OW) ? HW : OW) + 1;

    logic [HW-1:0] r_head [LEVELS];
    logic [OW-1:0] r_occ  [LEVELS];

    t_in_item  r_item;
    t_status   r_status;
    logic [2:0] r_res_lvl;
    t_out_item r_out;

    logic          enc_any;
    logic [LW-1:0] enc_lvl;
    logic [LW+2:0] lvl_ext;
    logic [LW+2:0] enc_ext;
    logic [LW-1:0] ins_lvl;
    logic [LW-1:0] sel;
    logic          is_del;
    logic          in_range;
    logic          ins_ok;
    logic [HW-1:0] cur_head;
    logic [OW-1:0] cur_occ;
    logic [SW-1:0] tail_sum;
    logic [SW-1:0] tail_wrap;
    logic [HW:0]   head_sum;
    logic [HW-1:0] next_head;
    logic [HW-1:0] slot;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic          ram_re;
    logic [31:0]   ram_rdata;
    t_status       exec_status;

    always_comb begin
        enc_any = 1'b0;
        enc_lvl = '0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (r_occ[l] != '0) begin
                enc_any = 1'b1;
                enc_lvl = LW'(l);
            end
        end
    end

    assign is_del   = (r_item.op == OP_DELETE);
    assign lvl_ext  = (LW + 3)'(r_item.level);
    assign ins_lvl  = lvl_ext[LW-1:0];
    assign enc_ext  = (LW + 3)'(enc_lvl);
    assign in_range = (int'(r_item.level) < LEVELS);
    assign sel      = is_del ? enc_lvl : ins_lvl;
    assign cur_head = r_head[sel];
    assign cur_occ  = r_occ[sel];
    assign ins_ok   = in_range && (cur_occ < OW'(SLOTS_PER_LEVEL));

    assign tail_sum  = SW'(cur_head) + SW'(cur_occ);
    assign tail_wrap = (tail_sum >= SW'(SLOTS_PER_LEVEL)) ?
                       tail_sum - SW'(SLOTS_PER_LEVEL) : tail_sum;
    assign head_sum  = (HW + 1)'(cur_head) + (HW + 1)'(1);
    assign next_head = (head_sum >= (HW + 1)'(SLOTS_PER_LEVEL)) ? '0 : head_sum[HW-1:0];

    assign slot     = is_del ? cur_head : tail_wrap[HW-1:0];
    assign ram_addr = AW'(int'(sel) * SLOTS_PER_LEVEL + int'(slot));
    assign ram_we   = i_cmd.exec && !is_del && ins_ok;
    assign ram_re   = i_cmd.exec && is_del && enc_any;

    always_comb begin
        if (is_del) begin
            exec_status = enc_any ? ST_REMOVED : ST_EMPTY;
        end else begin
            exec_status = ins_ok ? ST_INSERTED : ST_OVERFLOW;
        end
    end

    mlpq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (r_item.item_value),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < LEVELS; l++) begin
                r_head[l] <= '0;
                r_occ[l]  <= '0;
            end
        end else if (i_cmd.exec) begin
            if (is_del && enc_any) begin
                r_head[sel] <= next_head;
                r_occ[sel]  <= cur_occ - OW'(1);
            end else if (!is_del && ins_ok) begin
                r_occ[sel]  <= cur_occ + OW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_status  <= exec_status;
            r_res_lvl <= enc_ext[2:0];
        end
        if (i_cmd.load_out) begin
            r_out.status <= r_status;
            if (r_status == ST_REMOVED) begin
                r_out.out_value <= ram_rdata;
                r_out.out_level <= r_res_lvl;
            end else begin
                r_out.out_value <= '0;
                r_out.out_level <= '0;
            end
        end
    end

    assign o_out_data = r_out;

endmodule

[sv/multi_level_priority_queue_top.sv]
// Multi-level priority queue: one circular FIFO per priority level.
// Depends on mlpq_pkg, mlpq_ctrl, mlpq_dp and mlpq_ram.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat is an insert
// of item_value into FIFO `level`, or a delete that pops the oldest value of
// the lowest-numbered non-empty level.
// Output channel (o_out_valid / i_out_ready / o_out_data): exactly one beat
// per input beat, in order: inserted, overflow, removed (with value and
// level) or queue empty.
// Steps per item: register the item, update the level pointers and access the
// slot RAM, load the result register. The block takes no new item until the
// result of the last one is loaded. Delete reads the slot RAM through its
// registered read port, whose data the result register loads in the last step.
// A stalled receiver holds the result register; the block still accepts and
// executes one more item, then holds it and takes no new one until the
// result register frees.
// Reset (synchronous, active low) empties every level at once; slot contents
// are not cleared.
module multi_level_priority_queue_top #(
    parameter int LEVELS          = 8,
    parameter int SLOTS_PER_LEVEL = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mlpq_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mlpq_pkg::t_out_item o_out_data
);
    import mlpq_pkg::*;

    t_cmd cmd;

    mlpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    mlpq_dp #(
        .LEVELS          (LEVELS),
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule

[dv/tb_top.sv]
// Testbench for multi_level_priority_queue_top: a directed table, then random insert and
// delete beats checked against a per-level FIFO predictor, with random stalls on both sides.
// Depends on mlpq_pkg and the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mlpq_pkg::*;

    localparam int NUM_LEVELS   = 8;
    localparam int LEVEL_SLOTS  = 5;
    localparam int RAND_BEATS   = 550;
    localparam int QUIET_TAIL   = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        t_in_item  beat;
        bit        typed;
        t_out_item want;
    } t_row;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    // sideband travelling with the driven beat
    bit        beat_typed;
    t_out_item beat_want;

    logic signed [31:0] slot_mem [NUM_LEVELS*LEVEL_SLOTS];
    int                 lvl_head [NUM_LEVELS];
    int                 lvl_count [NUM_LEVELS];

    t_out_item pending_results [$];
    t_row      rows [$];
    int        errors;
    int        cycle_count;
    bit        quiet;

    multi_level_priority_queue_top #(
        .LEVELS          (NUM_LEVELS),
        .SLOTS_PER_LEVEL (LEVEL_SLOTS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic t_out_item pq_predict(t_in_item it);
        t_out_item r;
        int        lv;
        int        tail;
        int        h;
        bit        found;
        r = '0;
        lv = it.level;
        if (it.op == OP_INSERT) begin
            if (lv >= NUM_LEVELS || lvl_count[lv] >= LEVEL_SLOTS) begin
                r.status = ST_OVERFLOW;
            end else begin
                tail = lvl_head[lv] + lvl_count[lv];
                if (tail >= LEVEL_SLOTS) tail -= LEVEL_SLOTS;
                slot_mem[lv*LEVEL_SLOTS + tail] = it.item_value;
                lvl_count[lv]++;
                r.status = ST_INSERTED;
            end
        end else begin
            found = 0;
            r.status = ST_EMPTY;
            for (int l = 0; l < NUM_LEVELS; l++) begin
                if (!found && lvl_count[l] != 0) begin
                    h = lvl_head[l];
                    r.out_value = slot_mem[l*LEVEL_SLOTS + h];
                    r.out_level = 3'(l);
                    r.status = ST_REMOVED;
                    lvl_head[l] = (h + 1 >= LEVEL_SLOTS) ? h + 1 - LEVEL_SLOTS : h + 1;
                    lvl_count[l]--;
                    found = 1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch %s got %0h want %0h at cycle %0d", what, got, want, cycle_count);
        errors++;
    endtask

    task automatic add_row(logic op, logic [31:0] val, logic [2:0] lvl, bit typed,
                           t_status st, logic [31:0] oval, logic [2:0] olev);
        t_row r;
        r.beat.op = op;
        r.beat.item_value = val;
        r.beat.level = lvl;
        r.typed = typed;
        r.want.status = st;
        r.want.out_value = oval;
        r.want.out_level = olev;
        rows.push_back(r);
    endtask

    task automatic send_beat(t_row r);
        int n;
        if (!quiet && $urandom_range(4) == 0) begin
            n = $urandom_range(1, 19);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= r.beat;
        beat_typed <= r.typed;
        beat_want  <= r.want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // scoreboard: predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_out_item model;
        t_out_item want;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                model = pq_predict(i_in_data);
                pending_results.push_back(beat_typed ? beat_want : model);
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("unexpected beat", 64'(o_out_data), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status)
                        report_mismatch("status", 64'(o_out_data.status), 64'(want.status));
                    if (o_out_data.out_value !== want.out_value)
                        report_mismatch("out_value", 64'(o_out_data.out_value),
                                        64'(want.out_value));
                    if (o_out_data.out_level !== want.out_level)
                        report_mismatch("out_level", 64'(o_out_data.out_level),
                                        64'(want.out_level));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int n;
        i_out_ready = 1'b0;
        forever begin
            if (!quiet && $urandom_range(3) == 0) begin
                n = $urandom_range(1, 19);
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b0;
                end
            end else begin
                n = $urandom_range(1, 30);
                repeat (n) begin
                    @(negedge i_clk);
                    i_out_ready <= 1'b1;
                end
            end
        end
    end

    initial begin
        t_row r;
        int   ins_pct;
        int   lvl_hi;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        beat_typed  = 0;
        beat_want   = '0;
        errors      = 0;
        cycle_count = 0;
        quiet       = 0;
        foreach (slot_mem[i]) slot_mem[i] = '0;
        foreach (lvl_head[i]) begin
            lvl_head[i]  = 0;
            lvl_count[i] = 0;
        end
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_row(OP_DELETE, 32'h0, 3'd0, 1, ST_EMPTY, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h7fffffff, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h80000000, 3'd7, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h1, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h2, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h3, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h4, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        // level 0 now full
        add_row(OP_INSERT, 32'h5, 3'd0, 1, ST_OVERFLOW, 32'h0, 3'd0);
        add_row(OP_DELETE, 32'hffffffff, 3'd7, 1, ST_REMOVED, 32'h7fffffff, 3'd0);
        // tail wraps around
        add_row(OP_INSERT, 32'h6, 3'd0, 1, ST_INSERTED, 32'h0, 3'd0);
        repeat (5) add_row(OP_DELETE, 32'h0, 3'd0, 0, ST_EMPTY, 32'h0, 3'd0);
        add_row(OP_DELETE, 32'h0, 3'd0, 1, ST_REMOVED, 32'h80000000, 3'd7);
        add_row(OP_DELETE, 32'h0, 3'd0, 1, ST_EMPTY, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'hffffffff, 3'd3, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_INSERT, 32'h0, 3'd2, 1, ST_INSERTED, 32'h0, 3'd0);
        add_row(OP_DELETE, 32'hdeadbeef, 3'd7, 0, ST_EMPTY, 32'h0, 3'd0);
        add_row(OP_DELETE, 32'h5a5a5a5a, 3'd5, 0, ST_EMPTY, 32'h0, 3'd0);
        add_row(OP_DELETE, 32'h0, 3'd0, 1, ST_EMPTY, 32'h0, 3'd0);

        foreach (rows[i]) send_beat(rows[i]);

        for (int i = 0; i < RAND_BEATS; i++) begin
            case ((i / 50) % 4)
                0: ins_pct = 85;
                1: ins_pct = 50;
                2: ins_pct = 20;
                default: ins_pct = 60;
            endcase
            lvl_hi = ((i / 25) % 3 == 0) ? 1 : 7;
            quiet = (i >= RAND_BEATS - QUIET_TAIL);
            r.typed = 0;
            r.want = '0;
            r.beat.op = ($urandom_range(99) < ins_pct) ? OP_INSERT : OP_DELETE;
            case ($urandom_range(7))
                0: r.beat.item_value = 32'h7fffffff;
                1: r.beat.item_value = 32'h80000000;
                2: r.beat.item_value = 32'h0;
                3: r.beat.item_value = 32'hffffffff;
                default: r.beat.item_value = $urandom;
            endcase
            r.beat.level = (r.beat.op == OP_INSERT) ? 3'($urandom_range(lvl_hi))
                                                    : 3'($urandom_range(7));
            send_beat(r);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
